FILE: hw/rtl/ia2d_pkg.sv
package ia2d_pkg;

  localparam int COORD_BITS = 16;
  localparam int FRAC_BITS  = 8;
  localparam int DIV_W      = COORD_BITS + FRAC_BITS;
  localparam int ALU_W      = DIV_W + 1;
  localparam int CNT_W      = $clog2(DIV_W);
  localparam int TAN_W      = 15;
  localparam int IDX_W      = 7;
  localparam int BIT_W      = 3;
  localparam int ANG_W      = 9;

  localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(89);
  localparam logic [BIT_W-1:0] TOP_BIT   = BIT_W'(IDX_W - 1);
  localparam logic [ANG_W-1:0] ANG_RIGHT = ANG_W'(90);
  localparam logic [ANG_W-1:0] ANG_HALF  = ANG_W'(180);
  localparam logic [ANG_W-1:0] ANG_FULL  = ANG_W'(360);

  typedef struct packed {
    logic             borrow;
    logic [ALU_W-1:0] diff;
  } alu_res_t;

  function automatic logic [TAN_W-1:0] tan_lut(input logic [IDX_W-1:0] idx);
    logic [TAN_W-1:0] v;
    case (idx)
      7'd0:  v = 15'd0;     7'd1:  v = 15'd4;     7'd2:  v = 15'd8;
      7'd3:  v = 15'd13;    7'd4:  v = 15'd17;    7'd5:  v = 15'd22;
      7'd6:  v = 15'd26;    7'd7:  v = 15'd31;    7'd8:  v = 15'd35;
      7'd9:  v = 15'd40;    7'd10: v = 15'd45;    7'd11: v = 15'd49;
      7'd12: v = 15'd54;    7'd13: v = 15'd59;    7'd14: v = 15'd63;
      7'd15: v = 15'd68;    7'd16: v = 15'd73;    7'd17: v = 15'd78;
      7'd18: v = 15'd83;    7'd19: v = 15'd88;    7'd20: v = 15'd93;
      7'd21: v = 15'd98;    7'd22: v = 15'd103;   7'd23: v = 15'd108;
      7'd24: v = 15'd113;   7'd25: v = 15'd119;   7'd26: v = 15'd124;
      7'd27: v = 15'd130;   7'd28: v = 15'd136;   7'd29: v = 15'd141;
      7'd30: v = 15'd147;   7'd31: v = 15'd153;   7'd32: v = 15'd159;
      7'd33: v = 15'd166;   7'd34: v = 15'd172;   7'd35: v = 15'd179;
      7'd36: v = 15'd185;   7'd37: v = 15'd192;   7'd38: v = 15'd200;
      7'd39: v = 15'd207;   7'd40: v = 15'd214;   7'd41: v = 15'd222;
      7'd42: v = 15'd230;   7'd43: v = 15'd238;   7'd44: v = 15'd247;
      7'd45: v = 15'd256;   7'd46: v = 15'd265;   7'd47: v = 15'd274;
      7'd48: v = 15'd284;   7'd49: v = 15'd294;   7'd50: v = 15'd305;
      7'd51: v = 15'd316;   7'd52: v = 15'd327;   7'd53: v = 15'd339;
      7'd54: v = 15'd352;   7'd55: v = 15'd365;   7'd56: v = 15'd379;
      7'd57: v = 15'd394;   7'd58: v = 15'd409;   7'd59: v = 15'd426;
      7'd60: v = 15'd443;   7'd61: v = 15'd461;   7'd62: v = 15'd481;
      7'd63: v = 15'd502;   7'd64: v = 15'd524;   7'd65: v = 15'd548;
      7'd66: v = 15'd574;   7'd67: v = 15'd603;   7'd68: v = 15'd633;
      7'd69: v = 15'd666;   7'd70: v = 15'd703;   7'd71: v = 15'd743;
      7'd72: v = 15'd787;   7'd73: v = 15'd837;   7'd74: v = 15'd892;
      7'd75: v = 15'd955;   7'd76: v = 15'd1026;  7'd77: v = 15'd1108;
      7'd78: v = 15'd1204;  7'd79: v = 15'd1317;  7'd80: v = 15'd1451;
      7'd81: v = 15'd1616;  7'd82: v = 15'd1821;  7'd83: v = 15'd2085;
      7'd84: v = 15'd2435;  7'd85: v = 15'd2926;  7'd86: v = 15'd3661;
      7'd87: v = 15'd4885;  7'd88: v = 15'd7331;  7'd89: v = 15'd14669;
      default: v = '1;
    endcase
    return v;
  endfunction

endpackage

FILE: hw/rtl/ia2d_alu.sv
module ia2d_alu
  import ia2d_pkg::*;
(
  input  logic [ALU_W-1:0] a_i,
  input  logic [ALU_W-1:0] b_i,
  output alu_res_t         res_o
);

  logic [ALU_W:0] full;

  assign full          = {1'b0, a_i} - {1'b0, b_i};
  assign res_o.diff    = full[ALU_W-1:0];
  assign res_o.borrow  = full[ALU_W];

endmodule

FILE: hw/rtl/integer_atan2_degrees.sv
// Channel | Beat fields                     | Handshake
// in      | x_distance_i, y_distance_i      | in_valid_i / in_stall_o
// out     | angle_degrees_o                 | out_valid_o / out_stall_i
//
// Each beat is captured, divided by the (COORD_BITS + 8)-bit restoring divide
// one quotient bit at a time, matched by a bitwise table search, and folded.
// Both divide and search run through the single shared subtract unit.
// Reset clears the sequencer and the output valid; there is no clearing pass.
// The output register holds a stalled result while the next beat is accepted;
// the fold step waits until that register is free.
module integer_atan2_degrees
  import ia2d_pkg::*;
(
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic signed [COORD_BITS-1:0] x_distance_i,
  input  logic signed [COORD_BITS-1:0] y_distance_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [ANG_W-1:0]             angle_degrees_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_SRCH,
    ST_FOLD
  } state_e;

  state_e                state_q, state_d;
  logic [COORD_BITS-1:0] ax_q, ax_d;
  logic [COORD_BITS-1:0] rem_q, rem_d;
  logic [DIV_W-1:0]      div_q, div_d;
  logic [CNT_W-1:0]      cnt_q, cnt_d;
  logic [IDX_W-1:0]      k_q, k_d;
  logic [BIT_W-1:0]      bit_q, bit_d;
  logic                  xneg_q, xneg_d;
  logic                  yneg_q, yneg_d;
  logic                  xzero_q, xzero_d;
  logic                  out_valid_q, out_valid_d;
  logic [ANG_W-1:0]      angle_q, angle_d;

  logic [COORD_BITS-1:0] x_mag, y_mag;
  logic [COORD_BITS:0]   rem_shift;
  logic [IDX_W-1:0]      cand;
  logic [ALU_W-1:0]      alu_a, alu_b;
  alu_res_t              alu_res;
  logic [ANG_W-1:0]      base;
  logic [ANG_W-1:0]      folded;
  logic                  accept;
  logic                  out_free;

  assign accept   = in_valid_i && !in_stall_o;
  assign out_free = !out_valid_q || !out_stall_i;

  assign x_mag = x_distance_i[COORD_BITS-1] ? (~x_distance_i + 1'b1) : x_distance_i;
  assign y_mag = y_distance_i[COORD_BITS-1] ? (~y_distance_i + 1'b1) : y_distance_i;

  assign rem_shift = {rem_q, div_q[DIV_W-1]};
  assign cand      = k_q | (IDX_W'(1) << bit_q);

  always_comb begin
    if (state_q == ST_SRCH) begin
      alu_a = ALU_W'(div_q);
      alu_b = ALU_W'(tan_lut(cand));
    end else begin
      alu_a = ALU_W'(rem_shift);
      alu_b = ALU_W'(ax_q);
    end
  end

  ia2d_alu u_alu (
    .a_i   (alu_a),
    .b_i   (alu_b),
    .res_o (alu_res)
  );

  assign base = xzero_q ? ANG_RIGHT : ANG_W'(k_q);

  always_comb begin
    if (!xneg_q) begin
      folded = yneg_q ? (ANG_FULL - base) : base;
    end else begin
      folded = yneg_q ? (ANG_HALF + base) : (ANG_HALF - base);
    end
  end

  always_comb begin
    state_d     = state_q;
    ax_d        = ax_q;
    rem_d       = rem_q;
    div_d       = div_q;
    cnt_d       = cnt_q;
    k_d         = k_q;
    bit_d       = bit_q;
    xneg_d      = xneg_q;
    yneg_d      = yneg_q;
    xzero_d     = xzero_q;
    angle_d     = angle_q;
    out_valid_d = out_valid_q && out_stall_i;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          ax_d    = x_mag;
          div_d   = {y_mag, FRAC_BITS'(0)};
          rem_d   = '0;
          cnt_d   = CNT_W'(DIV_W - 1);
          xneg_d  = x_distance_i[COORD_BITS-1];
          yneg_d  = y_distance_i[COORD_BITS-1];
          xzero_d = (x_distance_i == '0);
          state_d = ST_DIV;
        end
      end
      ST_DIV: begin
        if (!alu_res.borrow) begin
          rem_d = alu_res.diff[COORD_BITS-1:0];
          div_d = {div_q[DIV_W-2:0], 1'b1};
        end else begin
          rem_d = rem_shift[COORD_BITS-1:0];
          div_d = {div_q[DIV_W-2:0], 1'b0};
        end
        cnt_d = cnt_q - 1'b1;
        if (cnt_q == '0) begin
          k_d     = '0;
          bit_d   = TOP_BIT;
          state_d = ST_SRCH;
        end
      end
      ST_SRCH: begin
        if (cand <= LAST_IDX && !alu_res.borrow) begin
          k_d = cand;
        end
        bit_d = bit_q - 1'b1;
        if (bit_q == '0) begin
          state_d = ST_FOLD;
        end
      end
      ST_FOLD: begin
        if (out_free) begin
          angle_d     = folded;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      ax_q        <= '0;
      rem_q       <= '0;
      div_q       <= '0;
      cnt_q       <= '0;
      k_q         <= '0;
      bit_q       <= '0;
      xneg_q      <= 1'b0;
      yneg_q      <= 1'b0;
      xzero_q     <= 1'b0;
      angle_q     <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      ax_q        <= ax_d;
      rem_q       <= rem_d;
      div_q       <= div_d;
      cnt_q       <= cnt_d;
      k_q         <= k_d;
      bit_q       <= bit_d;
      xneg_q      <= xneg_d;
      yneg_q      <= yneg_d;
      xzero_q     <= xzero_d;
      angle_q     <= angle_d;
    end
  end

  assign in_stall_o      = (state_q != ST_IDLE);
  assign out_valid_o     = out_valid_q;
  assign angle_degrees_o = angle_q;

  a_angle_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> angle_degrees_o <= ANG_FULL)
    else $error("angle out of range");

  a_accept_starts_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> state_q == ST_DIV)
    else $error("accepted beat did not start divide");

  a_rem_below_divisor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV && !xzero_q) |-> rem_q < ax_q)
    else $error("partial remainder not below divisor");

  a_index_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SRCH || state_q == ST_FOLD) |-> k_q <= LAST_IDX)
    else $error("table index past last entry");

endmodule
